// ===== src/swm_pkg.sv =====
package swm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int WS_W     = 7;
	localparam logic [WS_W-1:0] WS_RESET = 7'd3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_BACK,
		ST_CMP,
		ST_PUSH,
		ST_RD_FRONT,
		ST_EMIT
	} state_t;

	// strobes from sequencer to datapath
	typedef struct packed {
		logic in_ready;
		logic ld_in;
		logic rd_back;
		logic pop;
		logic push;
		logic emit;
		logic finish;
	} ctrl_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic in_valid;
		logic q_empty;
		logic back_lt;
		logic emit_req;
		logic out_free;
	} stat_t;

endpackage

// ===== src/swm_seq.sv =====
module swm_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  swm_pkg::stat_t stat,
	output swm_pkg::ctrl_t ctrl
);

	swm_pkg::state_t state_q;
	swm_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			swm_pkg::ST_IDLE: begin
				if (stat.in_valid) state_nxt = swm_pkg::ST_RD_BACK;
			end
			swm_pkg::ST_RD_BACK: begin
				state_nxt = swm_pkg::ST_CMP;
			end
			swm_pkg::ST_CMP: begin
				if (!stat.q_empty && stat.back_lt) state_nxt = swm_pkg::ST_RD_BACK;
				else state_nxt = swm_pkg::ST_PUSH;
			end
			swm_pkg::ST_PUSH: begin
				if (stat.emit_req) state_nxt = swm_pkg::ST_RD_FRONT;
				else state_nxt = swm_pkg::ST_IDLE;
			end
			swm_pkg::ST_RD_FRONT: begin
				state_nxt = swm_pkg::ST_EMIT;
			end
			swm_pkg::ST_EMIT: begin
				if (stat.out_free) state_nxt = swm_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = swm_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			swm_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.ld_in    = stat.in_valid;
			end
			swm_pkg::ST_RD_BACK: begin
				ctrl.rd_back = 1'b1;
			end
			swm_pkg::ST_CMP: begin
				ctrl.pop = !stat.q_empty && stat.back_lt;
			end
			swm_pkg::ST_PUSH: begin
				ctrl.push   = 1'b1;
				ctrl.finish = !stat.emit_req;
			end
			swm_pkg::ST_RD_FRONT: begin
			end
			swm_pkg::ST_EMIT: begin
				ctrl.emit   = stat.out_free;
				ctrl.finish = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/sliding_window_maximum_top.sv =====
// Sliding window maximum over a stream of signed 32-bit samples.
// Input transactions (sample, last_in_sequence) use in_valid/in_ready;
// result transactions (window_max, final_result) use out_valid/out_ready.
// cfg_we writes window_size from cfg_data; write it only while idle.
// A window_size of 0 acts as 1, above MAX_WINDOW acts as MAX_WINDOW.
// One compare unit walks the candidate queue from the back: for each entry
// the sequencer reads it (RD_BACK) and compares it (CMP), then pushes
// (PUSH), then RD_FRONT and EMIT when the item yields a result, then IDLE.
// The result shows on out_valid at the end of that item.
// Results are held in an output register: a new transaction is accepted
// while a result waits; only the next result stalls until out_ready.
// A sequence gives results from its window_size-th sample on; a
// transaction flagged last ends the sequence and clears the queue, ring
// pointer and sample count. Reset clears the same state, empties the
// output register and sets window_size to 3; no clearing pass is needed.
module sliding_window_maximum_top #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
	input  logic                               last_in_sequence,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [swm_pkg::SAMPLE_W-1:0] window_max,
	output logic                               final_result,
	input  logic                               cfg_we,
	input  logic [swm_pkg::WS_W-1:0]           cfg_data
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int IDX_W = CNT_W + 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);

	swm_pkg::ctrl_t ctrl;
	swm_pkg::stat_t stat;

	logic [swm_pkg::WS_W-1:0]     ws_q;
	logic [swm_pkg::SAMPLE_W-1:0] s_q;
	logic                         last_q;
	logic [CNT_W-1:0]             k_q;
	logic                         emit_q;
	logic [CNT_W-1:0]             seen_q;
	logic [CNT_W-1:0]             count_q;
	logic [PTR_W-1:0]             head_q;
	logic [PTR_W-1:0]             tail_q;
	logic [PTR_W-1:0]             rp_q;
	logic [swm_pkg::SAMPLE_W-1:0] q_rd_q;
	logic [swm_pkg::SAMPLE_W-1:0] r_rd_q;
	logic                         out_valid_q;
	logic [swm_pkg::SAMPLE_W-1:0] window_max_q;
	logic                         final_q;

	logic [swm_pkg::SAMPLE_W-1:0] queue_mem [MAX_WINDOW];
	logic [swm_pkg::SAMPLE_W-1:0] ring_mem  [MAX_WINDOW];

	logic [CNT_W-1:0] k_eff;
	logic [CNT_W-1:0] seen_clamp;
	logic [CNT_W-1:0] seen_nxt;
	logic [PTR_W-1:0] tail_dec;
	logic [PTR_W-1:0] q_raddr;
	logic [IDX_W-1:0] idx_raw;
	logic [IDX_W-1:0] idx_wrap;
	logic [PTR_W-1:0] r_raddr;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// effective window and running sample count
	always_comb begin
		if (ws_q == '0) k_eff = CNT_W'(1);
		else if (int'(ws_q) > MAX_WINDOW) k_eff = CNT_W'(MAX_WINDOW);
		else k_eff = CNT_W'(ws_q);
		seen_clamp = (seen_q > k_eff) ? k_eff : seen_q;
		seen_nxt   = (seen_clamp < k_eff) ? seen_clamp + 1'b1 : seen_clamp;
	end

	// queue read address: back during RD_BACK, front otherwise
	assign tail_dec = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;
	assign q_raddr  = ctrl.rd_back ? tail_dec : head_q;

	// ring slot of the sample leaving the window
	assign idx_raw  = IDX_W'(rp_q) + IDX_W'(MAX_WINDOW) - IDX_W'(k_q) + IDX_W'(1);
	assign idx_wrap = (idx_raw >= IDX_W'(MAX_WINDOW)) ? idx_raw - IDX_W'(MAX_WINDOW) : idx_raw;
	assign r_raddr  = idx_wrap[PTR_W-1:0];

	// status toward the sequencer
	assign stat.in_valid = in_valid;
	assign stat.q_empty  = (count_q == '0);
	assign stat.back_lt  = $signed(q_rd_q) < $signed(s_q);
	assign stat.emit_req = emit_q;
	assign stat.out_free = !out_valid_q || out_ready;

	swm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// candidate queue and history ring memories
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			queue_mem[tail_q] <= s_q;
			ring_mem[rp_q]    <= s_q;
		end
		q_rd_q <= queue_mem[q_raddr];
		r_rd_q <= ring_mem[r_raddr];
	end

	// latched transaction
	always_ff @(posedge clk) begin
		if (ctrl.ld_in) begin
			s_q    <= sample;
			last_q <= last_in_sequence;
			k_q    <= k_eff;
			emit_q <= (seen_nxt == k_eff);
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= swm_pkg::WS_RESET;
		end else if (cfg_we) begin
			ws_q <= cfg_data;
		end
	end

	// queue pointers, ring pointer, sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			rp_q    <= '0;
		end else if (ctrl.finish && last_q) begin
			// end of sequence: clear everything
			seen_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			rp_q    <= '0;
		end else begin
			if (ctrl.ld_in) seen_q <= seen_nxt;
			if (ctrl.pop) begin
				tail_q  <= tail_dec;
				count_q <= count_q - 1'b1;
			end else if (ctrl.push) begin
				tail_q <= ptr_inc(tail_q);
				// full queue: drop the front to make room
				if (count_q == CNT_W'(MAX_WINDOW)) head_q <= ptr_inc(head_q);
				else count_q <= count_q + 1'b1;
			end else if (ctrl.emit && (r_rd_q == q_rd_q)) begin
				// front leaves with the window
				head_q  <= ptr_inc(head_q);
				count_q <= count_q - 1'b1;
			end
			if (ctrl.finish) rp_q <= ptr_inc(rp_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			window_max_q <= q_rd_q;
			final_q      <= last_q;
		end
	end

	assign in_ready     = ctrl.in_ready;
	assign out_valid    = out_valid_q;
	assign window_max   = window_max_q;
	assign final_result = final_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_WINDOW  = 64;
	localparam int SETTLE_CYC  = 160;   // covers the worst item, plus margin
	localparam int HOLD_CYC    = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1750;

	typedef logic signed [swm_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic [swm_pkg::WS_W-1:0] win_t;

	typedef struct {
		sample_t value;
		logic    last;
	} sample_item_t;

	typedef struct {
		sample_t peak;
		logic    closing;
	} max_result_t;

	typedef enum int {
		SHAPE_NOISE,
		SHAPE_NARROW,
		SHAPE_FALL,
		SHAPE_RISE,
		SHAPE_CORNER
	} shape_e;

	// window size as the block applies it
	function automatic int unsigned window_span(int unsigned ws);
		if (ws == 0) return 1;
		if (ws > MAX_WINDOW) return MAX_WINDOW;
		return ws;
	endfunction

	// tracks the candidate queue and history ring, holds expected maxima
	class window_max_checker;
		int unsigned   win_reg;
		sample_t       cand[$];
		sample_t       hist[MAX_WINDOW];
		int unsigned   ptr;
		int unsigned   seen;
		max_result_t   expected_maxima[$];
		int unsigned   errors;

		function new();
			win_reg = swm_pkg::WS_RESET;
			ptr = 0;
			seen = 0;
			errors = 0;
			foreach (hist[i]) hist[i] = '0;
		endfunction

		function void write_window(win_t v);
			win_reg = v;
		endfunction

		function int unsigned pending();
			return expected_maxima.size();
		endfunction

		function void take_sample(sample_t s, logic lst);
			int unsigned k;
			int unsigned idx;
			max_result_t r;
			k = window_span(win_reg);
			// pop smaller candidates off the back, then push
			while (cand.size() > 0 && cand[$] < s) cand.delete(cand.size() - 1);
			if (cand.size() >= MAX_WINDOW) cand.delete(0);
			cand.insert(cand.size(), s);
			hist[ptr] = s;
			if (seen > k) seen = k;
			if (seen < k) seen++;
			// window full: front is the maximum; retire it if it leaves now
			if (seen >= k) begin
				r.peak = cand[0];
				r.closing = lst;
				expected_maxima.insert(expected_maxima.size(), r);
				idx = (ptr + MAX_WINDOW - (k - 1)) % MAX_WINDOW;
				if (hist[idx] == cand[0]) cand.delete(0);
			end
			ptr = (ptr + 1) % MAX_WINDOW;
			if (lst) begin
				cand.delete();
				ptr = 0;
				seen = 0;
			end
		endfunction

		function void compare_result(sample_t mx, logic fin);
			max_result_t r;
			if (expected_maxima.size() == 0) begin
				errors++;
				$error("result with no sample pending: window_max %0d final_result %0b",
					mx, fin);
				return;
			end
			r = expected_maxima[0];
			expected_maxima.delete(0);
			if (mx !== r.peak) begin
				errors++;
				$error("window_max: expected %0d, actual %0d", r.peak, mx);
			end
			if (fin !== r.closing) begin
				errors++;
				$error("final_result: expected %0b, actual %0b", r.closing, fin);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	sample_t             sample = '0;
	logic                last_in_sequence = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	sample_t             window_max;
	logic                final_result;
	logic                cfg_we = 1'b0;
	win_t                cfg_data = '0;

	window_max_checker   chk;
	sample_item_t        stim_q[$];
	int unsigned         samples_queued;
	int unsigned         stall_cycles = 0;
	bit                  sender_calm = 0;
	bit                  receiver_calm = 0;
	bit                  hold_request = 0;

	sliding_window_maximum_top #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.last_in_sequence(last_in_sequence),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.window_max(window_max),
		.final_result(final_result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// transaction monitor: results first, then the accepted sample, then config
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) chk.compare_result(window_max, final_result);
			if (in_valid && in_ready) chk.take_sample(sample, last_in_sequence);
			if (cfg_we) chk.write_window(cfg_data);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random back-pressure, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_request = 0;
			end else begin
				out_ready <= receiver_calm || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	function automatic void add_sample(sample_t v, logic lst);
		sample_item_t it;
		it.value = v;
		it.last = lst;
		stim_q.insert(stim_q.size(), it);
		samples_queued++;
	endfunction

	function automatic sample_t corner_value();
		case ($urandom_range(0, 4))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// one sequence of len samples; ends marks the last one as last_in_sequence
	function automatic void add_sequence(int unsigned len, shape_e shape, bit ends);
		sample_t v;
		sample_t step;
		sample_t cur;
		v = sample_t'($urandom);
		step = sample_t'($urandom_range(1, 1000));
		for (int unsigned i = 0; i < len; i++) begin
			case (shape)
				SHAPE_NARROW: cur = sample_t'($urandom_range(0, 6)) - 3;
				SHAPE_FALL: begin
					cur = v;
					v = v - step;
				end
				SHAPE_RISE: begin
					cur = v;
					v = v + step;
				end
				SHAPE_CORNER: cur = corner_value();
				default: cur = sample_t'($urandom);
			endcase
			add_sample(cur, ends && (i == len - 1));
		end
	endfunction

	function automatic win_t pick_window();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 6))
				0: return win_t'(0);
				1: return win_t'(1);
				2: return win_t'(2);
				3: return win_t'(63);
				4: return win_t'(64);
				5: return win_t'(65);
				default: return win_t'(127);
			endcase
		end
		if (r == 1) return win_t'($urandom_range(0, 127));
		return win_t'($urandom_range(1, 8));
	endfunction

	function automatic int unsigned pick_length(int unsigned k);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2 && k > 1) return $urandom_range(1, k - 1);
		if (r < 8) return k + $urandom_range(0, 24);
		return k + $urandom_range(25, 80);
	endfunction

	// drive every queued sample, with random gaps unless the sender is calm
	task automatic play();
		sample_item_t it;
		while (stim_q.size() > 0) begin
			it = stim_q[0];
			stim_q.delete(0);
			if (!sender_calm) begin
				while ($urandom_range(0, 99) < 15) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
			end
			in_valid <= 1'b1;
			sample <= it.value;
			last_in_sequence <= it.last;
			do @(posedge clk); while (!in_ready);
		end
		in_valid <= 1'b0;
	endtask

	// wait for all results, then for any item still in work without one
	task automatic drain();
		while (chk.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic load_window(win_t v);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(win_t ws);
		load_window(ws);
		play();
		drain();
	endtask

	initial begin
		win_t            ws;
		int unsigned     k;
		int unsigned     nseq;
		chk = new();
		samples_queued = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset window of 3 with field extremes, then a short sequence
		add_sample(32'sh7fff_ffff, 1'b0);
		add_sample(32'sh8000_0000, 1'b0);
		add_sample('0, 1'b0);
		add_sample(-1, 1'b0);
		add_sample(32'sh8000_0000, 1'b1);
		add_sample(5, 1'b0);
		add_sample(6, 1'b1);
		play();
		drain();
		// window of one
		add_sample(32'sh8000_0000, 1'b0);
		add_sample(32'sh7fff_ffff, 1'b0);
		add_sample(-1, 1'b1);
		run_phase(win_t'(1));
		// zero acts as one
		add_sample(5, 1'b0);
		add_sample(-5, 1'b1);
		run_phase(win_t'(0));
		// oversize window clamps to the depth; short sequence gives nothing
		add_sample(1, 1'b0);
		add_sample(2, 1'b0);
		add_sample(3, 1'b1);
		run_phase(win_t'(127));
		// equal samples stay queued and leave one by one
		add_sample(7, 1'b0);
		add_sample(7, 1'b0);
		add_sample(7, 1'b0);
		add_sample(7, 1'b1);
		run_phase(win_t'(2));

		// long stretch without idling on either side
		sender_calm = 1;
		receiver_calm = 1;
		add_sequence(120, SHAPE_NOISE, 1);
		run_phase(win_t'(2));
		sender_calm = 0;
		receiver_calm = 0;

		// receiver holds off while the sender keeps offering
		add_sequence(40, SHAPE_NOISE, 1);
		load_window(win_t'(1));
		hold_request = 1;
		play();
		drain();

		// shrink the window mid-sequence on a falling ramp until the queue overflows
		add_sequence(40, SHAPE_FALL, 0);
		run_phase(win_t'(64));
		add_sequence(60, SHAPE_FALL, 1);
		run_phase(win_t'(2));

		// random phases; some leave a sequence open across a window change
		while (samples_queued < RANDOM_ITEMS) begin
			ws = pick_window();
			k = window_span(ws);
			nseq = $urandom_range(1, 3);
			for (int unsigned s = 0; s < nseq; s++) begin
				add_sequence(pick_length(k), shape_e'($urandom_range(0, 4)),
					(s + 1 < nseq) || ($urandom_range(0, 9) >= 3));
			end
			run_phase(ws);
		end

		if (chk.errors == 0 && chk.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
